[rtl/tcam_pkg.sv]
// Shared types, constants and helpers of the texture coordinate addressing block.
`default_nettype none

package tcam_pkg;

  // Largest texture side in texels and width of a signed coordinate.
  localparam int MAX_DIM     = 4096;
  localparam int COORD_BITS  = 21;

  // Field widths fixed by the interface.
  localparam int CFG_BITS    = 13;
  localparam int UV_BITS     = 12;
  localparam int IDX_BITS    = 24;

  // Effective size needs to hold MAX_DIM; a resolved position holds MAX_DIM-1.
  localparam int DIM_BITS    = $clog2(MAX_DIM + 1);
  localparam int RES_BITS    = $clog2(MAX_DIM);
  localparam int PART_BITS   = RES_BITS + 1;
  localparam int WIDE_BITS   = COORD_BITS + DIM_BITS;
  localparam int PROD_BITS   = RES_BITS + DIM_BITS;

  // Divider pipeline: one quotient bit per step, a few steps per stage.
  localparam int DIV_STEPS     = COORD_BITS;
  localparam int STEPS_PER_STG = 3;
  localparam int DIV_STG       = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

  // Axis pipeline: input stage, divider stages, floor-mod stage, mode select stage.
  localparam int AX_STG  = DIV_STG + 3;
  // Whole block: axis stages, index multiply stage, output stage.
  localparam int TOT_STG = AX_STG + 2;

  // Reset value of both size registers.
  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(256);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT = 1'b1;

  // Address mode codes; code three decodes as clamp.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_WRAP   = 2'd0;
  localparam mode_t MODE_MIRROR = 2'd1;
  localparam mode_t MODE_CLAMP  = 2'd2;

  // Per-stage load enables handed to each axis pipeline.
  typedef struct packed {
    logic [AX_STG-1:0] load;
  } tcam_ctl_t;

  // Size used for addressing: zero acts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] r);
    logic [DIM_BITS-1:0] s;
    if (r == '0) begin
      s = DIM_BITS'(1);
    end else if (WIDE_BITS'(r) > WIDE_BITS'(MAX_DIM)) begin
      s = DIM_BITS'(MAX_DIM);
    end else begin
      s = DIM_BITS'(r);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/texture_coord_address_mode.sv]
// Top level of the texture coordinate addresser: handshakes, size registers, index.
//
//   channel  direction  handshake          payload
//   in       request    in_valid/in_stall  coord_u, coord_v, address_mode
//   out      result     out_valid/out_stall texel_u, texel_v, texel_index
//   cfg      write      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A request passes TOT_STG register stages (12 at the default sizes): one input
// stage, seven divider stages of three quotient bits, floor-mod, mode select, index
// multiply and output stage. While in_stall is low, one request is taken every cycle.
// Reset clears all valid bits and loads 256 into both size registers.
// A stall at the output only holds the stages that are full; empty stages keep
// filling, so in_stall rises only when every stage holds a request.
`default_nettype none

module texture_coord_address_mode (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tcam_pkg::COORD_BITS-1:0] coord_u,
  input  logic signed [tcam_pkg::COORD_BITS-1:0] coord_v,
  input  tcam_pkg::mode_t                        address_mode,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [tcam_pkg::UV_BITS-1:0]           texel_u,
  output logic [tcam_pkg::UV_BITS-1:0]           texel_v,
  output logic [tcam_pkg::IDX_BITS-1:0]          texel_index,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tcam_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [tcam_pkg::CFG_BITS-1:0]          cfg_data
);
  import tcam_pkg::*;

  logic [CFG_BITS-1:0]  tex_width;
  logic [CFG_BITS-1:0]  tex_height;
  logic [DIM_BITS-1:0]  w_eff;
  logic [DIM_BITS-1:0]  h_eff;

  logic [TOT_STG-1:0]   vld;
  logic [TOT_STG-1:0]   vld_next;
  logic [TOT_STG-1:0]   ok;
  tcam_ctl_t            ctl;

  logic [RES_BITS-1:0]  ru;
  logic [RES_BITS-1:0]  rv;
  logic [RES_BITS-1:0]  ru_m;
  logic [RES_BITS-1:0]  rv_m;
  logic [PROD_BITS-1:0] prod;

  // Size registers; the user must write them only while the block is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= CFG_RESET;
      tex_height <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(tex_width);
  assign h_eff = eff_size(tex_height);

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    ok[TOT_STG-1] = !vld[TOT_STG-1] || !out_stall;
    for (int i = TOT_STG - 2; i >= 0; i--) begin
      ok[i] = !vld[i] || ok[i+1];
    end
  end

  assign in_stall = !ok[0];
  assign ctl.load = ok[AX_STG-1:0];
  assign vld_next = {vld[TOT_STG-2:0], in_valid};

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < TOT_STG; i++) begin
        if (ok[i]) begin
          vld[i] <= vld_next[i];
        end
      end
    end
  end

  // The two axis pipelines.
  tcam_axis u_axis_u (
    .clk     (clk),
    .ctl     (ctl),
    .coord   (coord_u),
    .mode_in (address_mode),
    .size    (w_eff),
    .res     (ru)
  );

  tcam_axis u_axis_v (
    .clk     (clk),
    .ctl     (ctl),
    .coord   (coord_v),
    .mode_in (address_mode),
    .size    (h_eff),
    .res     (rv)
  );

  // Row times width.
  always_ff @(posedge clk) begin
    if (ok[AX_STG]) begin
      prod <= PROD_BITS'(rv) * PROD_BITS'(w_eff);
      ru_m <= ru;
      rv_m <= rv;
    end
  end

  // Output register: add the column and present the result.
  always_ff @(posedge clk) begin
    if (ok[TOT_STG-1]) begin
      texel_index <= IDX_BITS'(prod + PROD_BITS'(ru_m));
      texel_u     <= UV_BITS'(ru_m);
      texel_v     <= UV_BITS'(rv_m);
    end
  end

  assign out_valid = vld[TOT_STG-1];

  // The resolved column and row stay inside the configured texture.
  a_u_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (WIDE_BITS'(texel_u) < WIDE_BITS'(w_eff)))
    else $error("texel_u outside the texture width");

  a_v_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (WIDE_BITS'(texel_v) < WIDE_BITS'(h_eff)))
    else $error("texel_v outside the texture height");

  // Input backpressure only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with an empty stage");

  // An accepted request always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted request lost at the input stage");

endmodule

`default_nettype wire

[rtl/tcam_axis.sv]
// One axis of the addresser: pipelined divider, floor modulo and mode selection.
`default_nettype none

module tcam_axis (
  input  logic                               clk,
  input  tcam_pkg::tcam_ctl_t                ctl,
  input  logic signed [tcam_pkg::COORD_BITS-1:0] coord,
  input  tcam_pkg::mode_t                    mode_in,
  input  logic [tcam_pkg::DIM_BITS-1:0]      size,
  output logic [tcam_pkg::RES_BITS-1:0]      res
);
  import tcam_pkg::*;

  localparam int NC  = DIV_STG + 2;
  localparam int FM  = DIV_STG + 1;
  localparam int SEL = DIV_STG + 2;

  // Values that ride along with the divider.
  logic                  neg  [NC];
  mode_t                 mode [NC];
  logic [COORD_BITS-1:0] cmag [NC];

  // Divider state: remainder, dividend bits not yet consumed, last quotient bit.
  logic [RES_BITS-1:0]   rem  [DIV_STG+1];
  logic [COORD_BITS-1:0] sh   [DIV_STG+1];
  logic                  qb   [DIV_STG+1];

  logic [COORD_BITS-1:0] mag_in;
  logic [RES_BITS-1:0]   fmod;
  logic [RES_BITS-1:0]   fmod_next;
  logic [RES_BITS-1:0]   res_next;
  logic                  qodd;

  // Magnitude of the coordinate; the most negative value maps to its unsigned magnitude.
  assign mag_in = coord[COORD_BITS-1] ? (~coord + 1'b1) : coord;

  // Input stage.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      neg[0]  <= coord[COORD_BITS-1];
      mode[0] <= mode_in;
      cmag[0] <= mag_in;
      sh[0]   <= mag_in;
      rem[0]  <= '0;
      qb[0]   <= 1'b0;
    end
  end

  // Restoring divider, a few quotient bits per stage.
  for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
    logic [RES_BITS-1:0]   rem_next;
    logic [COORD_BITS-1:0] sh_next;
    logic                  qb_next;
    logic [PART_BITS-1:0]  part;

    always_comb begin
      rem_next = rem[k-1];
      sh_next  = sh[k-1];
      qb_next  = qb[k-1];
      part     = '0;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        if ((k - 1) * STEPS_PER_STG + j < DIV_STEPS) begin
          part    = {rem_next, sh_next[COORD_BITS-1]};
          sh_next = {sh_next[COORD_BITS-2:0], 1'b0};
          if (part >= PART_BITS'(size)) begin
            rem_next = RES_BITS'(part - PART_BITS'(size));
            qb_next  = 1'b1;
          end else begin
            rem_next = RES_BITS'(part);
            qb_next  = 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        rem[k]  <= rem_next;
        sh[k]   <= sh_next;
        qb[k]   <= qb_next;
        neg[k]  <= neg[k-1];
        mode[k] <= mode[k-1];
        cmag[k] <= cmag[k-1];
      end
    end
  end

  // Floor modulo from the truncated remainder: a negative coordinate with
  // a nonzero remainder folds back from the size.
  assign fmod_next = (neg[DIV_STG] && (rem[DIV_STG] != '0))
                   ? RES_BITS'(size - DIM_BITS'(rem[DIV_STG]))
                   : rem[DIV_STG];

  always_ff @(posedge clk) begin
    if (ctl.load[FM]) begin
      fmod     <= fmod_next;
      qodd     <= qb[DIV_STG];
      neg[FM]  <= neg[DIV_STG];
      mode[FM] <= mode[DIV_STG];
      cmag[FM] <= cmag[DIV_STG];
    end
  end

  // Mode selection. Mirror reflects when the truncated quotient is odd.
  always_comb begin
    unique case (mode[FM])
      MODE_WRAP: begin
        res_next = fmod;
      end
      MODE_MIRROR: begin
        res_next = qodd ? RES_BITS'(size - DIM_BITS'(1) - DIM_BITS'(fmod)) : fmod;
      end
      default: begin
        if (neg[FM]) begin
          res_next = '0;
        end else if (WIDE_BITS'(cmag[FM]) >= WIDE_BITS'(size)) begin
          res_next = RES_BITS'(size - DIM_BITS'(1));
        end else begin
          res_next = RES_BITS'(cmag[FM]);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[SEL]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the texture coordinate addresser: random requests, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import tcam_pkg::*;

  // Run length and stimulus shape.
  localparam int           ITEMS_PER_PHASE = 58;
  localparam int           PHASES          = 10;
  localparam int unsigned  CYCLE_LIMIT     = 200000;
  localparam longint       COORD_MAX       = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint       COORD_MIN       = -(64'sd1 <<< (COORD_BITS - 1));
  // Code three is not named in the package; the block decodes it as clamp.
  localparam mode_t        MODE_CLAMP_ALT  = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One resolved texel as the block reports it.
  typedef struct packed {
    logic [UV_BITS-1:0]  u;
    logic [UV_BITS-1:0]  v;
    logic [IDX_BITS-1:0] idx;
  } texel_t;

  // Scoreboard: keeps its own copy of the size registers and the texels still due.
  class texel_scoreboard;
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    texel_t              due_q[$];
    int unsigned         errors;
    int unsigned         requests;
    int unsigned         results;

    function new();
      width_reg  = CFG_RESET;
      height_reg = CFG_RESET;
      errors     = 0;
      requests   = 0;
      results    = 0;
    endfunction

    function void write_size(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      if (idx == REG_TEX_WIDTH) begin
        width_reg = data;
      end else begin
        height_reg = data;
      end
    endfunction

    // A zero register acts as one texel, anything past the largest side as that side.
    function longint side_of(logic [CFG_BITS-1:0] r);
      if (r == '0) return 1;
      if (longint'(r) > MAX_DIM) return MAX_DIM;
      return longint'(r);
    endfunction

    function longint width_eff();
      return side_of(width_reg);
    endfunction

    function longint height_eff();
      return side_of(height_reg);
    endfunction

    // Resolve one axis. Mirror takes its parity from the quotient truncated toward zero.
    function longint fold_axis(longint c, longint d, mode_t m);
      longint r;
      longint q;
      if (m[1]) begin
        if (c < 0) return 0;
        if (c > d - 1) return d - 1;
        return c;
      end
      r = c % d;
      if (r < 0) r += d;
      if (m == MODE_MIRROR) begin
        q = c / d;
        if ((q & 64'sd1) != 0) return (d - 1) - r;
      end
      return r;
    endfunction

    function void note_request(coord_t cu, coord_t cv, mode_t m);
      longint w;
      longint h;
      longint ru;
      longint rv;
      longint lin;
      texel_t t;
      w   = width_eff();
      h   = height_eff();
      ru  = fold_axis(longint'(cu), w, m);
      rv  = fold_axis(longint'(cv), h, m);
      lin = rv * w + ru;
      t.u   = ru[UV_BITS-1:0];
      t.v   = rv[UV_BITS-1:0];
      t.idx = lin[IDX_BITS-1:0];
      due_q.push_back(t);
      requests++;
    endfunction

    function void check_result(logic [UV_BITS-1:0] u, logic [UV_BITS-1:0] v,
                               logic [IDX_BITS-1:0] idx);
      texel_t t;
      results++;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result u=%0d v=%0d index=%0d", $time, u, v, idx);
        errors++;
        return;
      end
      t = due_q.pop_front();
      if (u !== t.u) begin
        $display("%0t: texel_u expected %0d got %0d", $time, t.u, u);
        errors++;
      end
      if (v !== t.v) begin
        $display("%0t: texel_v expected %0d got %0d", $time, t.v, v);
        errors++;
      end
      if (idx !== t.idx) begin
        $display("%0t: texel_index expected %0d got %0d", $time, t.idx, idx);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction

    function void final_check();
      if (due_q.size() != 0) begin
        $display("%0t: %0d results never arrived, first expected u=%0d v=%0d index=%0d",
                 $time, due_q.size(), due_q[0].u, due_q[0].v, due_q[0].idx);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  coord_t                   coord_u;
  coord_t                   coord_v;
  mode_t                    address_mode;
  logic                     out_valid;
  logic                     out_stall;
  logic [UV_BITS-1:0]       texel_u;
  logic [UV_BITS-1:0]       texel_v;
  logic [IDX_BITS-1:0]      texel_index;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]      cfg_data;

  texel_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycle_count;
  int unsigned     settings_count;

  texture_coord_address_mode i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .coord_u      (coord_u),
    .coord_v      (coord_v),
    .address_mode (address_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .texel_u      (texel_u),
    .texel_v      (texel_v),
    .texel_index  (texel_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter ends a run that hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at random, changing only at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(texel_u, texel_v, texel_index);
    end
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic send_request(input longint cu, input longint cv, input mode_t m);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    coord_u      <= coord_t'(cu);
    coord_v      <= coord_t'(cv);
    address_mode <= m;
    do @(posedge clk); while (in_stall);
    sb.note_request(coord_t'(cu), coord_t'(cv), m);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected result has come, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TOT_STG) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_size(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coordinates: full range, near the texture, on period edges, or at the extremes.
  function automatic coord_t pick_coord(longint d);
    int unsigned sel;
    longint      c;
    longint      kmax;
    longint      k;
    sel = $urandom_range(9);
    if (sel <= 3) begin
      c = longint'(coord_t'($urandom));
    end else if (sel <= 6) begin
      c = longint'($urandom_range(32'(8 * d))) - 4 * d;
    end else if (sel <= 8) begin
      kmax = COORD_MAX / d;
      k    = longint'($urandom_range(32'(2 * kmax))) - kmax;
      c    = k * d + longint'($urandom_range(2)) - 1;
    end else begin
      c = ($urandom_range(1) == 0) ? COORD_MIN : COORD_MAX;
    end
    if (c > COORD_MAX) c = COORD_MAX;
    if (c < COORD_MIN) c = COORD_MIN;
    return coord_t'(c);
  endfunction

  // Main sequence: reset, directed requests, then one random phase per size setting.
  initial begin
    int unsigned         phase_w [PHASES];
    int unsigned         phase_h [PHASES];
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] h;
    phase_w = '{256, 1, 0, 4096, 8191, 3, 4095, 0, 256, 2};
    phase_h = '{256, 1, 0, 4096, 5000, 7, 2, 0, 4097, 1};
    sb             = new();
    settings_count = 1;
    idle_pct       = 0;
    stall_pct      = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    coord_u        = '0;
    coord_v        = '0;
    address_mode   = MODE_WRAP;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_TEX_WIDTH;
    cfg_data       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset size: field extremes, period edges, every mode.
    send_request(0, 0, MODE_WRAP);
    send_request(-1, -1, MODE_WRAP);
    send_request(255, 256, MODE_WRAP);
    send_request(-256, -257, MODE_WRAP);
    send_request(1048575, -1048576, MODE_WRAP);
    send_request(-1048576, 1048575, MODE_WRAP);
    // Mirror: a small negative coordinate has quotient zero and lands on the far edge.
    send_request(-1, -1, MODE_MIRROR);
    send_request(256, 511, MODE_MIRROR);
    send_request(-256, -257, MODE_MIRROR);
    send_request(512, 767, MODE_MIRROR);
    send_request(-513, 300, MODE_MIRROR);
    send_request(1048575, -1048576, MODE_MIRROR);
    send_request(-5, 300, MODE_CLAMP);
    send_request(255, 0, MODE_CLAMP);
    send_request(256, -1, MODE_CLAMP);
    send_request(1048575, -1048576, MODE_CLAMP);
    // Code three behaves as clamp.
    send_request(-1, 1000, MODE_CLAMP_ALT);
    send_request(100, 256, MODE_CLAMP_ALT);
    send_request(1048575, -1048576, MODE_CLAMP_ALT);
    drop_valid();

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 7) begin
        w = CFG_BITS'($urandom_range(8191));
        h = CFG_BITS'($urandom_range(8191));
      end else begin
        w = CFG_BITS'(phase_w[p]);
        h = CFG_BITS'(phase_h[p]);
      end
      write_size(REG_TEX_WIDTH, w);
      write_size(REG_TEX_HEIGHT, h);
      settings_count++;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once, hold the sender back until the pipeline has emptied.
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          drop_valid();
          while (sb.outstanding() != 0) @(posedge clk);
        end
        send_request(pick_coord(sb.width_eff()), pick_coord(sb.height_eff()),
                     mode_t'($urandom_range(3)));
      end
      drop_valid();
    end

    wait_drained();
    sb.final_check();
    $display("Sent %0d requests and checked %0d results under %0d texture sizes,",
             sb.requests, sb.results, settings_count);
    $display("covering wrap, mirror, clamp and code three, zero and oversized sizes.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tcam_pkg.sv
rtl/tcam_axis.sv
rtl/texture_coord_address_mode.sv
test/tb_top.sv
